[rtl/psls_pkg.sv]
// Shared constants, command and register codes and types for the step latency monitor.
`timescale 1ns / 1ps

package psls_pkg;

   // Field widths of the channels
   localparam int CMD_W       = 2;
   localparam int STEP_W      = 4;
   localparam int TIME_W      = 48;
   localparam int COUNT_W     = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int STEPS_CFG_W = 5;

   // Fraction bits of the running mean
   localparam int FRAC_BITS = 16;

   // Defaults for the top-level parameters
   localparam int MAX_STEPS_DEF  = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [STEPS_CFG_W-1:0] STEPS_RESET = 5'd16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS  = 1'b1;

   // Slot store control
   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } mem_ctl_type;

endpackage

[rtl/psls_ifs.sv]
// Valid/ready channel interfaces: command items, result items and register writes.
`timescale 1ns / 1ps

interface psls_req_if;
   import psls_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [STEP_W-1:0] step_index;
   logic [TIME_W-1:0] time_us;

   modport source (output valid, cmd, step_index, time_us, input ready);
   modport sink   (input valid, cmd, step_index, time_us, output ready);
endinterface

interface psls_rsp_if;
   import psls_pkg::*;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               has_data;
   logic [TIME_W-1:0]  max_us;
   logic [TIME_W-1:0]  min_us;
   logic [TIME_W-1:0]  average_us;
   logic [COUNT_W-1:0] sample_count;

   modport source (output valid, accepted, has_data, max_us, min_us, average_us,
                   sample_count, input ready);
   modport sink   (input valid, accepted, has_data, max_us, min_us, average_us,
                   sample_count, output ready);
endinterface

interface psls_csr_if;
   import psls_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/per_step_latency_statistics.sv]
// Top level of the per-step latency monitor: sequencer, slot store and mean divider.
`timescale 1ns / 1ps

// Per-step latency monitor. Each numbered step owns a slot holding a start stamp,
// the largest and smallest duration, a sample count and a running mean in
// unsigned fixed point with 16 fraction bits. A start item stamps the slot, an
// end item takes the stamp, clears it and, for an ordered nonzero pair, records
// the duration; a read item returns the slot's figures, and a clear item empties
// every slot at once (per-slot valid bits, no sweep). One item is in work at a
// time and req_ch.ready is high only while the sequencer is idle. Clear and
// rejected items go straight to the result; start and read items first read the
// slot, an end item that records nothing (or whose count wraps) then passes the
// update state, and one that records a duration then waits for the restoring
// divider, which forms the mean step one quotient bit a cycle. The sequencer is
// idle again in the cycle that the result appears and takes the next item from
// there, later if the previous result is still waiting. Slots live in a
// single-port store read through a register. Register writes are always taken
// and must only occur while idle.
module per_step_latency_statistics #(
   parameter int MAX_STEPS  = psls_pkg::MAX_STEPS_DEF,
   parameter int TIME_BITS  = psls_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = psls_pkg::COUNT_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   psls_req_if.sink   req_ch,
   psls_rsp_if.source rsp_ch,
   psls_csr_if.sink   csr_ch
);
   import psls_pkg::*;

   localparam int T      = TIME_BITS;
   localparam int C      = COUNT_BITS;
   localparam int M      = TIME_BITS + FRAC_BITS;  // mean width
   localparam int SLOT_W = $clog2(MAX_STEPS);
   localparam int WORD_W = 3 * T + M + C;

   // slot word layout, low to high: count, mean, min, max, start stamp
   localparam int MEAN_LO = C;
   localparam int MIN_LO  = C + M;
   localparam int MAX_LO  = C + M + T;
   localparam int ST_LO   = C + M + 2 * T;

   localparam logic [WORD_W-1:0] RESET_WORD = {{T{1'b0}}, {T{1'b0}}, {T{1'b1}},
                                               {M{1'b0}}, {C{1'b0}}};

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;  // slot word arrives
   localparam logic [2:0] S_UPDATE = 3'd2;  // max, min, count, mean difference
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;  // apply mean step
   localparam logic [2:0] S_DONE   = 3'd5;  // hand result to output register

   logic [2:0]             state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [T-1:0]           now_ff, now_in;
   logic [T-1:0]           max_ff, max_in;
   logic [T-1:0]           min_ff, min_in;
   logic [M-1:0]           mean_ff, mean_in;
   logic [C-1:0]           cnt_ff, cnt_in;
   logic [T-1:0]           dur_ff, dur_in;
   logic                   ordered_ff, ordered_in;
   logic                   neg_ff, neg_in;
   logic                   acc_ff, acc_in;
   logic                   enable_ff, enable_in;
   logic [STEPS_CFG_W-1:0] steps_ff, steps_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic                   rsp_has_ff, rsp_has_in;
   logic [TIME_W-1:0]      rsp_max_ff, rsp_max_in;
   logic [TIME_W-1:0]      rsp_min_ff, rsp_min_in;
   logic [TIME_W-1:0]      rsp_avg_ff, rsp_avg_in;
   logic [COUNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic                   req_fire;
   logic                   step_ok;
   logic [SLOT_W+STEP_W-1:0] step_wide;
   mem_ctl_type            mem_ctl;
   logic [SLOT_W-1:0]      mem_addr;
   logic [WORD_W-1:0]      wr_word;
   logic [WORD_W-1:0]      rd_word;

   logic [T-1:0]           rd_st, rd_max, rd_min;
   logic [M-1:0]           rd_mean;
   logic [C-1:0]           rd_cnt;

   logic [T-1:0]           new_max, new_min;
   logic [C-1:0]           new_cnt;
   logic [M-1:0]           dq, diff_up, diff_dn, mean_new;
   logic                   dq_ge;
   logic                   div_start, div_done;
   logic [M-1:0]           div_q;

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      steps_in  = steps_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ENABLE: enable_in = csr_ch.data[0];
            CSR_STEPS:  steps_in  = csr_ch.data[STEPS_CFG_W-1:0];
            default:    ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == S_IDLE);

   // a step is only valid while the configured count is below the slot store depth
   assign step_ok = (32'(steps_ff) < 32'(MAX_STEPS)) &&
                    ({1'b0, req_ch.step_index} < steps_ff);
   assign step_wide = {{SLOT_W{1'b0}}, req_ch.step_index};

   // ------------------------------------------------------------------
   // Slot word fields and datapath
   // ------------------------------------------------------------------
   assign rd_cnt  = rd_word[C-1:0];
   assign rd_mean = rd_word[MEAN_LO +: M];
   assign rd_min  = rd_word[MIN_LO +: T];
   assign rd_max  = rd_word[MAX_LO +: T];
   assign rd_st   = rd_word[ST_LO +: T];

   assign new_max = (max_ff < dur_ff) ? dur_ff : max_ff;
   assign new_min = (dur_ff < min_ff) ? dur_ff : min_ff;
   assign new_cnt = cnt_ff + 1'b1;

   // sign and magnitude of (duration << 16) - mean
   assign dq      = {dur_ff, {FRAC_BITS{1'b0}}};
   assign dq_ge   = dq >= mean_ff;
   assign diff_up = dq - mean_ff;
   assign diff_dn = mean_ff - dq;

   assign div_start = (state_ff == S_UPDATE) && ordered_ff && (new_cnt != '0);
   assign mean_new  = neg_ff ? (mean_ff - div_q) : (mean_ff + div_q);

   // the divisor is sampled only while dividing, when cnt_ff already holds
   // the incremented count
   psls_div #(
      .DIVIDEND_W (M),
      .DIVISOR_W  (C)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dq_ge ? diff_up : diff_dn),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // ------------------------------------------------------------------
   // Slot store access
   // ------------------------------------------------------------------
   assign mem_addr = (state_ff == S_IDLE) ? step_wide[SLOT_W-1:0] : slot_ff;

   always_comb begin
      mem_ctl = '0;
      wr_word = {{T{1'b0}}, max_ff, min_ff, mean_ff, cnt_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.cmd == CMD_CLEAR) begin
                  mem_ctl.clr = 1'b1;
               end else if (enable_ff && step_ok) begin
                  mem_ctl.rd = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (cmd_ff == CMD_START) begin
               mem_ctl.wr = 1'b1;
               wr_word    = {now_ff, rd_word[ST_LO-1:0]};
            end
         end
         S_UPDATE: begin
            if (!ordered_ff) begin
               // stamp is consumed even when nothing is recorded
               mem_ctl.wr = 1'b1;
            end else if (new_cnt == '0) begin
               // count wrapped: mean restarts from zero
               mem_ctl.wr = 1'b1;
               wr_word    = {{T{1'b0}}, new_max, new_min, {M{1'b0}}, new_cnt};
            end
         end
         S_FINISH: begin
            mem_ctl.wr = 1'b1;
            wr_word    = {{T{1'b0}}, max_ff, min_ff, mean_new, cnt_ff};
         end
         default: ;
      endcase
   end

   psls_slot_mem #(
      .DEPTH      (MAX_STEPS),
      .WIDTH      (WORD_W),
      .RESET_WORD (RESET_WORD)
   ) u_slots (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (wr_word),
      .rd_data (rd_word)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      slot_in    = slot_ff;
      now_in     = now_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      mean_in    = mean_ff;
      cnt_in     = cnt_ff;
      dur_in     = dur_ff;
      ordered_in = ordered_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_ch.cmd;
               slot_in = step_wide[SLOT_W-1:0];
               now_in  = req_ch.time_us[T-1:0];
               if (req_ch.cmd == CMD_CLEAR) begin
                  acc_in   = 1'b1;
                  state_in = S_DONE;
               end else if (enable_ff && step_ok) begin
                  acc_in   = 1'b1;
                  state_in = S_CHECK;
               end else begin
                  acc_in   = 1'b0;
                  state_in = S_DONE;
               end
            end
         end
         S_CHECK: begin
            max_in     = rd_max;
            min_in     = rd_min;
            mean_in    = rd_mean;
            cnt_in     = rd_cnt;
            dur_in     = now_ff - rd_st;
            ordered_in = (rd_st != '0) && (now_ff != '0) && (now_ff >= rd_st);
            state_in   = (cmd_ff == CMD_END) ? S_UPDATE : S_DONE;
         end
         S_UPDATE: begin
            if (!ordered_ff || (new_cnt == '0)) begin
               state_in = S_DONE;
            end else begin
               max_in   = new_max;
               min_in   = new_min;
               cnt_in   = new_cnt;
               neg_in   = !dq_ge;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               if (acc_ff && (cmd_ff == CMD_READ)) begin
                  rsp_has_in = (max_ff != '0);
                  rsp_max_in = TIME_W'(max_ff);
                  rsp_min_in = TIME_W'(min_ff);
                  rsp_avg_in = TIME_W'(mean_ff[M-1:FRAC_BITS]);
                  rsp_cnt_in = COUNT_W'(cnt_ff);
               end else begin
                  rsp_has_in = 1'b0;
                  rsp_max_in = '0;
                  rsp_min_in = '0;
                  rsp_avg_in = '0;
                  rsp_cnt_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         steps_ff     <= STEPS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         enable_ff    <= enable_in;
         steps_ff     <= steps_in;
      end
      cmd_ff     <= cmd_in;
      slot_ff    <= slot_in;
      now_ff     <= now_in;
      max_ff     <= max_in;
      min_ff     <= min_in;
      mean_ff    <= mean_in;
      cnt_ff     <= cnt_in;
      dur_ff     <= dur_in;
      ordered_ff <= ordered_in;
      neg_ff     <= neg_in;
      acc_ff     <= acc_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_has_ff <= rsp_has_in;
      rsp_max_ff <= rsp_max_in;
      rsp_min_ff <= rsp_min_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // ------------------------------------------------------------------
   // Result channel
   // ------------------------------------------------------------------
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = rsp_acc_ff;
   assign rsp_ch.has_data     = rsp_has_ff;
   assign rsp_ch.max_us       = rsp_max_ff;
   assign rsp_ch.min_us       = rsp_min_ff;
   assign rsp_ch.average_us   = rsp_avg_ff;
   assign rsp_ch.sample_count = rsp_cnt_ff;

endmodule

[rtl/psls_slot_mem.sv]
// Slot store: one word per step slot, registered read, per-slot valid bits for clear.
`timescale 1ns / 1ps

module psls_slot_mem #(
   parameter int                DEPTH      = 16,
   parameter int                WIDTH      = 64,
   parameter logic [WIDTH-1:0]  RESET_WORD = '0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  psls_pkg::mem_ctl_type      ctl,
   input  logic [$clog2(DEPTH)-1:0]   addr,
   input  logic [WIDTH-1:0]           wr_data,
   output logic [WIDTH-1:0]           rd_data
);
   import psls_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clr) begin
         valid_in = '0;
      end else if (ctl.wr) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff  <= mem[addr];
         rd_valid_ff <= valid_ff[addr];
      end
   end

   // never-written or cleared slots read as their reset contents
   assign rd_data = rd_valid_ff ? rd_data_ff : RESET_WORD;

endmodule

[rtl/psls_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module psls_div #(
   parameter int DIVIDEND_W = 64,
   parameter int DIVISOR_W  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   import psls_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] q_ff, q_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, q_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};
   assign done  = busy_ff && (cnt_ff == LAST);
   assign quotient = q_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the top bit drops safely
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         q_in   = {q_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

endmodule
